@@ src/skm_pkg.sv @@
package skm_pkg;

  localparam int KEY_W     = 32;
  localparam int PAY_W     = 12;
  localparam int COORD_W   = 3;
  localparam int RND_W     = 32;
  localparam int CNT_OUT_W = 10;
  localparam int DIV_STEPS = RND_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAVE,
    S_MOD,
    S_RESULT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             pick;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } skm_ctl_t;

  // token that walks the chain
  typedef struct packed {
    logic             live;
    logic             hit;
    logic [PAY_W-1:0] pay;
  } skm_wave_t;

endpackage

@@ src/sorted_key_multimap_random_pick.sv @@
// channel  | handshake                  | payload
// request  | req_valid / req_stall(out) | action key src_col src_row dst_col dst_row rand_value
// result   | rsp_valid / rsp_stall(in)  | status out_src_col out_src_row out_dst_col out_dst_row
//          |                            | match_count
// One request at a time. The time a request takes is set by the token walking the
// cell chain one cell a cycle (once to count and check, and for a lookup hit once
// more to pick) and by the 32-step remainder unit; an insert into a full table
// answers without a walk.
// Reset clears the entry count; cell contents are left as they are and never read.
// A result held by rsp_stall stays put; the next request is taken meanwhile.
module sorted_key_multimap_random_pick import skm_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               action,
  input  logic [KEY_W-1:0]   key,
  input  logic [COORD_W-1:0] src_col,
  input  logic [COORD_W-1:0] src_row,
  input  logic [COORD_W-1:0] dst_col,
  input  logic [COORD_W-1:0] dst_row,
  input  logic [RND_W-1:0]   rand_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [2:0]         status,
  output logic [COORD_W-1:0] out_src_col,
  output logic [COORD_W-1:0] out_src_row,
  output logic [COORD_W-1:0] out_dst_col,
  output logic [COORD_W-1:0] out_dst_row,
  output logic [CNT_OUT_W-1:0] match_count
);

  localparam int N  = TABLE_DEPTH;
  localparam int CW = $clog2(N + 1);

  state_t           state, state_next;
  action_t          act;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [RND_W-1:0] rnd_r;
  logic             pick, pick_next;
  logic [CW-1:0]    count;
  status_t          res_status, res_status_next;
  logic [PAY_W-1:0] res_pay, res_pay_next;
  logic [CW-1:0]    res_match, res_match_next;

  logic          launch;
  logic [CW-1:0] launch_cnt;
  logic          ins;
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_rem;
  logic          load_out;
  logic          accept;

  skm_ctl_t         ctl;
  logic             occ   [N];
  logic             le_a  [N];
  logic [KEY_W-1:0] key_a [N];
  logic [PAY_W-1:0] pay_a [N];
  skm_wave_t        wave_a [N+1];
  logic [CW-1:0]    cnt_a  [N+1];

  logic [CW+CNT_OUT_W-1:0] match_ext;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  assign ctl.ins  = ins;
  assign ctl.pick = pick;
  assign ctl.key  = key_r;
  assign ctl.pay  = pay_r;

  assign wave_a[0] = '{live: launch, hit: 1'b0, pay: '0};
  assign cnt_a[0]  = launch_cnt;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             lle;
    logic [KEY_W-1:0] lkey;
    logic [PAY_W-1:0] lpay;

    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      assign lle  = 1'b1;
      assign lkey = key_r;
      assign lpay = pay_r;
    end else begin : g_body
      assign lle  = le_a[i-1];
      assign lkey = key_a[i-1];
      assign lpay = pay_a[i-1];
    end

    skm_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .occ      (occ[i]),
      .left_le  (lle),
      .left_key (lkey),
      .left_pay (lpay),
      .le       (le_a[i]),
      .key      (key_a[i]),
      .pay      (pay_a[i]),
      .wave_in  (wave_a[i]),
      .cnt_in   (cnt_a[i]),
      .wave_out (wave_a[i+1]),
      .cnt_out  (cnt_a[i+1])
    );
  end

  skm_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (cnt_a[N]),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pick      <= 1'b0;
    end else begin
      state <= state_next;
      pick  <= pick_next;
      if (ins) begin
        count <= CW'(count + 1'b1);
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_pay    <= res_pay_next;
    res_match  <= res_match_next;
    if (accept) begin
      act   <= action_t'(action);
      key_r <= key;
      pay_r <= {src_col, src_row, dst_col, dst_row};
      rnd_r <= rand_value;
    end
  end

  assign match_ext = {{CNT_OUT_W{1'b0}}, res_match};

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      out_src_col <= res_pay[4*COORD_W-1:3*COORD_W];
      out_src_row <= res_pay[3*COORD_W-1:2*COORD_W];
      out_dst_col <= res_pay[2*COORD_W-1:COORD_W];
      out_dst_row <= res_pay[COORD_W-1:0];
      match_count <= match_ext[CNT_OUT_W-1:0];
    end
  end

  // pick is registered ahead of each launch so cell 0 sees the right mode
  always_comb begin
    state_next      = state;
    pick_next       = pick;
    res_status_next = res_status;
    res_pay_next    = res_pay;
    res_match_next  = res_match;
    launch          = 1'b0;
    launch_cnt      = '0;
    ins             = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          pick_next  = 1'b0;
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        res_pay_next   = '0;
        res_match_next = '0;
        if (act == ACT_INSERT && count == CW'(N)) begin
          res_status_next = ST_FULL;
          state_next      = S_RESULT;
        end else begin
          launch     = 1'b1;
          state_next = S_WAVE;
        end
      end
      S_WAVE: begin
        if (wave_a[N].live) begin
          state_next = S_RESULT;
          if (pick) begin
            res_status_next = ST_HIT;
            res_pay_next    = wave_a[N].pay;
          end else if (act == ACT_INSERT) begin
            if (wave_a[N].hit) begin
              res_status_next = ST_DUPLICATE;
            end else begin
              ins             = 1'b1;
              res_status_next = ST_INSERTED;
            end
          end else if (cnt_a[N] == '0) begin
            res_status_next = ST_MISS;
          end else begin
            res_match_next = cnt_a[N];
            div_start      = 1'b1;
            pick_next      = 1'b1;
            state_next     = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (div_done) begin
          launch     = 1'b1;
          launch_cnt = div_rem;
          state_next = S_WAVE;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/skm_cell.sv @@
module skm_cell import skm_pkg::*; #(
  parameter int CW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  skm_ctl_t         ctl,
  input  logic             occ,
  input  logic             left_le,
  input  logic [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0] left_pay,
  output logic             le,
  output logic [KEY_W-1:0] key,
  output logic [PAY_W-1:0] pay,
  input  skm_wave_t        wave_in,
  input  logic [CW-1:0]    cnt_in,
  output skm_wave_t        wave_out,
  output logic [CW-1:0]    cnt_out
);

  logic      eq;
  skm_wave_t wave_next;
  logic [CW-1:0] cnt_next;

  assign eq = occ && (key == ctl.key);
  assign le = occ && (key <= ctl.key);

  always_comb begin
    wave_next = wave_in;
    cnt_next  = cnt_in;
    if (eq) begin
      if (ctl.pick) begin
        if (!wave_in.hit) begin
          if (cnt_in == '0) begin
            wave_next.hit = 1'b1;
            wave_next.pay = pay;
          end else begin
            cnt_next = CW'(cnt_in - 1'b1);
          end
        end
      end else begin
        cnt_next = CW'(cnt_in + 1'b1);
        if (pay == ctl.pay) begin
          wave_next.hit = 1'b1;
        end
      end
    end
  end

  // stable insert: entries above the new key move one cell right
  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      if (left_le) begin
        key <= ctl.key;
        pay <= ctl.pay;
      end else begin
        key <= left_key;
        pay <= left_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_out <= cnt_next;
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

endmodule

@@ src/skm_mod.sv @@
module skm_mod import skm_pkg::*; #(
  parameter int CW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             done,
  output logic [CW-1:0]    rem
);

  localparam int SW = $clog2(DIV_STEPS);

  logic             busy;
  logic [SW-1:0]    step;
  logic [RND_W-1:0] dvd;
  logic [CW-1:0]    dsr;
  logic [CW:0]      rem_sh;

  assign rem_sh = {rem, dvd[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == SW'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == SW'(DIV_STEPS - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      rem  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      step <= SW'(step + 1'b1);
      dvd  <= {dvd[RND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= CW'(rem_sh - {1'b0, dsr});
      end else begin
        rem <= rem_sh[CW-1:0];
      end
    end
  end

endmodule

@@ src/skm_check.sv @@
module skm_check import skm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [2:0]         status,
  input logic [COORD_W-1:0] out_src_col,
  input logic [COORD_W-1:0] out_src_row,
  input logic [COORD_W-1:0] out_dst_col,
  input logic [COORD_W-1:0] out_dst_row,
  input logic [CNT_OUT_W-1:0] match_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(match_count)
      && $stable(out_src_col) && $stable(out_dst_row))
    else $error("held result changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without pending request");

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_HIT |-> match_count == '0 && out_src_col == '0
      && out_src_row == '0 && out_dst_col == '0 && out_dst_row == '0)
    else $error("nonzero fields on non-hit result");

endmodule

bind sorted_key_multimap_random_pick skm_check u_skm_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .out_src_col (out_src_col),
  .out_src_row (out_src_row),
  .out_dst_col (out_dst_col),
  .out_dst_row (out_dst_row),
  .match_count (match_count)
);

@@ verif/tb_sorted_key_multimap_random_pick.sv @@
module tb_sorted_key_multimap_random_pick import skm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 512;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE_TICKS = 2 * DEPTH + 100;

  typedef struct {
    action_t          act;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [RND_W-1:0] rnd;
    bit               drain;
  } move_req_t;

  typedef struct {
    status_t              st;
    logic [PAY_W-1:0]     pay;
    logic [CNT_OUT_W-1:0] cnt;
  } pick_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 action = 1'b0;
  logic [KEY_W-1:0]     key = '0;
  logic [COORD_W-1:0]   src_col = '0;
  logic [COORD_W-1:0]   src_row = '0;
  logic [COORD_W-1:0]   dst_col = '0;
  logic [COORD_W-1:0]   dst_row = '0;
  logic [RND_W-1:0]     rand_value = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [2:0]           status;
  logic [COORD_W-1:0]   out_src_col;
  logic [COORD_W-1:0]   out_src_row;
  logic [COORD_W-1:0]   out_dst_col;
  logic [COORD_W-1:0]   out_dst_row;
  logic [CNT_OUT_W-1:0] match_count;

  sorted_key_multimap_random_pick #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .key(key),
    .src_col(src_col), .src_row(src_row), .dst_col(dst_col), .dst_row(dst_row),
    .rand_value(rand_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status),
    .out_src_col(out_src_col), .out_src_row(out_src_row),
    .out_dst_col(out_dst_col), .out_dst_row(out_dst_row),
    .match_count(match_count)
  );

  always #4 clk = ~clk;

  move_req_t        pending_reqs[$];
  move_req_t        past_inserts[$];
  pick_t            expected_picks[$];
  logic [KEY_W-1:0] key_pool[16];

  // mirror of the sorted table
  logic [KEY_W-1:0] mirror_key[DEPTH];
  logic [PAY_W-1:0] mirror_pay[DEPTH];
  int               mirror_count = 0;

  int mismatches = 0;
  int reqs_sent = 0;
  int reqs_taken = 0;
  int status_seen[5] = '{default: 0};
  int longest_run = 0;
  int cycle_cnt = 0;

  // first index with key >= k, or with key > k when past is set
  function automatic int run_edge(logic [KEY_W-1:0] k, bit past);
    int lo, hi, mid;
    lo = 0;
    hi = mirror_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (past ? (mirror_key[mid] <= k) : (mirror_key[mid] < k)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic model_table_access(input action_t act, input logic [KEY_W-1:0] k,
                                    input logic [PAY_W-1:0] pay,
                                    input logic [RND_W-1:0] rnd);
    pick_t       e;
    int          lo, hi;
    logic [31:0] run;
    bit          dup;
    e.st  = ST_MISS;
    e.pay = '0;
    e.cnt = '0;
    lo = run_edge(k, 1'b0);
    hi = run_edge(k, 1'b1);
    if (act == ACT_INSERT) begin
      if (mirror_count >= DEPTH) begin
        e.st = ST_FULL;
      end else begin
        dup = 1'b0;
        for (int i = lo; i < hi; i++)
          if (mirror_pay[i] == pay) dup = 1'b1;
        if (dup) begin
          e.st = ST_DUPLICATE;
        end else begin
          for (int i = mirror_count; i > hi; i--) begin
            mirror_key[i] = mirror_key[i-1];
            mirror_pay[i] = mirror_pay[i-1];
          end
          mirror_key[hi] = k;
          mirror_pay[hi] = pay;
          mirror_count++;
          e.st = ST_INSERTED;
        end
      end
    end else if (hi > lo) begin
      run   = hi - lo;
      e.pay = mirror_pay[lo + int'(rnd % run)];
      e.cnt = run[CNT_OUT_W-1:0];
      e.st  = ST_HIT;
      if (hi - lo > longest_run) longest_run = hi - lo;
    end
    status_seen[e.st]++;
    expected_picks.push_back(e);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_pick();
    pick_t e;
    if (expected_picks.size() == 0) begin
      $error("unexpected result: status %0d match_count %0d", status, match_count);
      mismatches++;
    end else begin
      e = expected_picks.pop_front();
      cmp_field("status", e.st, status);
      cmp_field("out_src_col", e.pay[11:9], out_src_col);
      cmp_field("out_src_row", e.pay[8:6], out_src_row);
      cmp_field("out_dst_col", e.pay[5:3], out_dst_col);
      cmp_field("out_dst_row", e.pay[2:0], out_dst_row);
      cmp_field("match_count", e.cnt, match_count);
    end
  endtask

  // monitor: check results, then book the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_pick();
      if (req_valid && !req_stall) begin
        model_table_access(action_t'(action), key,
                           {src_col, src_row, dst_col, dst_row}, rand_value);
        reqs_taken <= reqs_taken + 1;
      end
    end
  end

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    move_req_t cur;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || reqs_taken == reqs_sent) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_picks.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        cur = pending_reqs.pop_front();
        action <= cur.act;
        key <= cur.key;
        {src_col, src_row, dst_col, dst_row} <= cur.pay;
        rand_value <= cur.rnd;
        req_valid <= 1'b1;
        reqs_sent++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // result side backpressure in stretches of 0, 50 or 90 percent
  int stall_left = 0;
  int stall_pct = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 50;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(5, 120);
    end
    stall_left--;
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_picks.size());
      $display("FAIL sorted_key_multimap_random_pick");
      $finish;
    end
  end

  task automatic add_req(input action_t act, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] pay, input logic [RND_W-1:0] rnd,
                         input bit drain = 1'b0);
    move_req_t r;
    r.act = act;
    r.key = k;
    r.pay = pay;
    r.rnd = rnd;
    r.drain = drain;
    pending_reqs.push_back(r);
    if (act == ACT_INSERT) past_inserts.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 30) return key_pool[2];
    if (r < 85) return key_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  function automatic logic [RND_W-1:0] pick_rnd();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_insert(input bit drain);
    move_req_t r;
    if (past_inserts.size() != 0 && $urandom_range(99) < 12) begin
      r = past_inserts[$urandom_range(past_inserts.size() - 1)];
      add_req(ACT_INSERT, r.key, r.pay, $urandom, drain);
    end else begin
      add_req(ACT_INSERT, pick_key(), $urandom_range(4095), $urandom, drain);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom;

    // directed: empty table, extreme keys and payloads, duplicates, runs
    add_req(ACT_LOOKUP, 32'h0, 12'hFFF, 32'hFFFF_FFFF);
    add_req(ACT_INSERT, 32'h0, 12'h000, 32'h0);
    add_req(ACT_INSERT, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
    add_req(ACT_INSERT, 32'h0, 12'h000, 32'h1234_5678);
    add_req(ACT_INSERT, 32'h0, 12'b111_000_111_000, 32'h0);
    add_req(ACT_INSERT, 32'h0, 12'b000_111_000_111, 32'h0);
    add_req(ACT_INSERT, 32'hFFFF_FFFF, 12'hFFF, 32'h0);
    add_req(ACT_INSERT, 32'h8000_0000, 12'b001_010_011_100, 32'h0);
    add_req(ACT_INSERT, 32'h7FFF_FFFF, 12'b100_011_010_001, 32'h0);
    add_req(ACT_LOOKUP, 32'h0, 12'hFFF, 32'h0);
    add_req(ACT_LOOKUP, 32'h0, 12'h000, 32'h1);
    add_req(ACT_LOOKUP, 32'h0, 12'hA5A, 32'h2);
    add_req(ACT_LOOKUP, 32'h0, 12'h5A5, 32'hFFFF_FFFF);
    add_req(ACT_LOOKUP, 32'hFFFF_FFFF, 12'h000, 32'h0);
    add_req(ACT_LOOKUP, 32'h8000_0000, 12'hFFF, 32'hAAAA_AAAA);
    add_req(ACT_LOOKUP, 32'h7FFF_FFFF, 12'h123, 32'h5555_5555);
    add_req(ACT_LOOKUP, 32'h1, 12'hFFF, 32'h7);
    add_req(ACT_LOOKUP, 32'hFFFF_FFFE, 12'hFFF, 32'hFFFF_FFFF);
    add_req(ACT_INSERT, 32'h0, 12'b111_000_111_000, 32'h0);
    add_req(ACT_INSERT, 32'h1, 12'b011_011_011_011, 32'h0);
    add_req(ACT_LOOKUP, 32'h1, 12'h000, 32'h7);

    // mixed traffic over a small key pool with one hot key
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(99) < 55) add_random_insert(1'b0);
      else add_req(ACT_LOOKUP, pick_key(), $urandom_range(4095), pick_rnd());
    end

    // wait for the block to drain, then fill the table past capacity
    for (int i = 0; i < 330; i++)
      add_req(ACT_INSERT, pick_key(), $urandom_range(4095), $urandom, i == 0);

    // full table: rejected inserts and long searches
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(99) < 30) add_random_insert(1'b0);
      else add_req(ACT_LOOKUP, pick_key(), $urandom_range(4095), pick_rnd());
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d requests: %0d inserted, %0d duplicate, %0d rejected on full table",
             reqs_taken, status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
             status_seen[ST_FULL]);
    $display("lookups: %0d hits (longest run %0d), %0d misses; final table size %0d",
             status_seen[ST_HIT], longest_run, status_seen[ST_MISS], mirror_count);
    if (mismatches == 0) begin
      $display("PASS sorted_key_multimap_random_pick");
    end else begin
      $display("FAIL sorted_key_multimap_random_pick");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/skm_pkg.sv
src/skm_cell.sv
src/skm_mod.sv
src/sorted_key_multimap_random_pick.sv
src/skm_check.sv
verif/tb_sorted_key_multimap_random_pick.sv
